[hdl/acs_pkg.sv]
// shared constants, types and codes for the checkerboard shade block
// no dependencies
package acs_pkg;

  localparam int CoordW     = 32;
  localparam int CellW      = 31;
  localparam int CountW     = 8;
  localparam int QuotW      = 8;
  localparam int LevelW     = 8;
  localparam int SqW        = 2 * CoordW;
  localparam int RootW      = CoordW;
  localparam int RootLat    = SqW / 2;
  localparam int LocLat     = QuotW + 1;
  localparam int FrontLat   = RootLat + 4;
  localparam int ProdW      = CountW + CellW;
  localparam int NumW       = CellW + 8;
  localparam int DivW       = RootW + QuotW;
  localparam int QueueDepth = 2;
  localparam int CfgIdxW    = 2;

  localparam logic [LevelW-1:0] MidLevel  = LevelW'(180);
  localparam logic [LevelW-1:0] MaxLevel  = LevelW'(255);
  localparam logic [LevelW-1:0] LightSpan = LevelW'(75);

  localparam logic [CountW-1:0] CellsXReset   = CountW'(8);
  localparam logic [CountW-1:0] CellsYReset   = CountW'(6);
  localparam logic [CellW-1:0]  CellSizeReset = CellW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CELLS_X   = 2'd0,
    CFG_CELLS_Y   = 2'd1,
    CFG_CELL_SIZE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_WHITE = 2'd0,
    KIND_LIGHT = 2'd1,
    KIND_DARK  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CellW-1:0]   gap;
    logic [RootW-1:0]   smooth;
  } job_t;

endpackage

[hdl/acs_locate.sv]
// cell index and grid line distance along one axis, bit per stage divider
// depends on acs_pkg
module acs_locate import acs_pkg::*; (
  input  logic              clk_i,
  input  logic [CellW-1:0]  pos_i,
  input  logic [CellW-1:0]  size_i,
  input  logic [CellW-1:0]  neg_m_i,
  input  logic              neg_i,
  output logic [CountW-1:0] idx_o,
  output logic [CellW-1:0]  dist_o
);

  typedef struct packed {
    logic [CellW-1:0] rem;
    logic [QuotW-1:0] quo;
    logic [CellW-1:0] size;
    logic [CellW-1:0] negm;
    logic             neg;
  } loc_stage_t;

  loc_stage_t        stg_in [QuotW];
  loc_stage_t        stg_nx [QuotW];
  loc_stage_t        stg_q  [QuotW];
  logic [ProdW-1:0]  trial  [QuotW];
  loc_stage_t        last;
  logic [CellW-1:0]  m;
  logic [CellW-1:0]  m_rest;
  logic [CountW-1:0] idx_d, idx_q;
  logic [CellW-1:0]  dist_d, dist_q;

  always_comb begin
    stg_in[0] = '{rem: pos_i, quo: '0, size: size_i, negm: neg_m_i, neg: neg_i};
    for (int k = 1; k < QuotW; k++) begin
      stg_in[k] = stg_q[k-1];
    end
    for (int k = 0; k < QuotW; k++) begin
      trial[k]  = ProdW'(stg_in[k].size) << (QuotW - 1 - k);
      stg_nx[k] = stg_in[k];
      if (ProdW'(stg_in[k].rem) >= trial[k]) begin
        stg_nx[k].rem = CellW'(ProdW'(stg_in[k].rem) - trial[k]);
        stg_nx[k].quo[QuotW-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QuotW; k++) begin
      stg_q[k] <= stg_nx[k];
    end
  end

  always_comb begin
    last   = stg_q[QuotW-1];
    m      = last.neg ? last.negm : last.rem;
    m_rest = last.size - m;
    idx_d  = last.neg ? '0 : last.quo + CountW'(last.rem != '0);
    dist_d = (m < m_rest) ? m : m_rest;
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    dist_q <= dist_d;
  end

  assign idx_o  = idx_q;
  assign dist_o = dist_q;

endmodule

[hdl/acs_isqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on acs_pkg
module acs_isqrt import acs_pkg::*; (
  input  logic             clk_i,
  input  logic [SqW-1:0]   sq_i,
  output logic [RootW-1:0] root_o
);

  typedef struct packed {
    logic [SqW-1:0] n;
    logic [SqW-1:0] r;
  } sq_stage_t;

  sq_stage_t      stg_in [RootLat];
  sq_stage_t      stg_nx [RootLat];
  sq_stage_t      stg_q  [RootLat];
  logic [SqW-1:0] bitv   [RootLat];
  logic [SqW-1:0] sum    [RootLat];

  always_comb begin
    stg_in[0] = '{n: sq_i, r: '0};
    for (int k = 1; k < RootLat; k++) begin
      stg_in[k] = stg_q[k-1];
    end
    for (int k = 0; k < RootLat; k++) begin
      bitv[k] = SqW'(1) << (SqW - 2 - 2 * k);
      sum[k]  = stg_in[k].r + bitv[k];
      if (stg_in[k].n >= sum[k]) begin
        stg_nx[k].n = stg_in[k].n - sum[k];
        stg_nx[k].r = (stg_in[k].r >> 1) + bitv[k];
      end else begin
        stg_nx[k].n = stg_in[k].n;
        stg_nx[k].r = stg_in[k].r >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RootLat; k++) begin
      stg_q[k] <= stg_nx[k];
    end
  end

  assign root_o = stg_q[RootLat-1].r[RootW-1:0];

endmodule

[hdl/acs_front.sv]
// front part: takes words, classifies the point, finds footprint lengths
// depends on acs_pkg, acs_locate, acs_isqrt
module acs_front import acs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] step_u_x_i,
  input  logic signed [CoordW-1:0] step_u_y_i,
  input  logic signed [CoordW-1:0] step_v_x_i,
  input  logic signed [CoordW-1:0] step_v_y_i,
  input  logic [CountW-1:0]        cells_x_i,
  input  logic [CountW-1:0]        cells_y_i,
  input  logic [CellW-1:0]         cell_size_i,
  output logic                     push_o,
  output job_t                     job_o
);

  typedef struct packed {
    logic              outside;
    logic [CountW-1:0] cells_x;
    logic [CountW-1:0] cells_y;
  } side_t;

  typedef struct packed {
    kind_e            kind;
    logic [CellW-1:0] gap;
  } cls_t;

  localparam int ClsDly = RootLat - LocLat;

  function automatic logic [CoordW-1:0] mag(input logic signed [CoordW-1:0] v);
    return v[CoordW-1] ? CoordW'(-v) : CoordW'(v);
  endfunction

  logic                     vld_q [FrontLat];
  logic signed [CoordW-1:0] px_q, py_q;
  logic [CoordW-1:0]        ua_q, ub_q, va_q, vb_q;
  logic [CellW-1:0]         c1_q;
  logic [CountW-1:0]        nx1_q, ny1_q;
  logic [ProdW-1:0]         nxc_q, nyc_q;
  logic [SqW-1:0]           uaa_q, ubb_q, vaa_q, vbb_q;
  logic [SqW-1:0]           su_q, sv_q;
  logic [CellW-1:0]         posx_q, posy_q, negmx_q, negmy_q, c2_q;
  logic                     negx_q, negy_q;
  side_t                    side_d;
  side_t                    side_q [LocLat+1];
  cls_t                     cls_d;
  cls_t                     cls_q [ClsDly+1];
  logic [CountW-1:0]        idx_x, idx_y;
  logic [CellW-1:0]         dist_x, dist_y;
  logic [RootW-1:0]         root_u, root_v;
  logic                     light, border;
  job_t                     job_q;
  logic signed [CoordW:0]   low_x, low_y;
  logic                     out_x, out_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FrontLat; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= accept_i;
      for (int k = 1; k < FrontLat; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // first stage: magnitudes and board extent
  always_ff @(posedge clk_i) begin
    px_q  <= point_x_i;
    py_q  <= point_y_i;
    ua_q  <= mag(step_u_x_i);
    ub_q  <= mag(step_u_y_i);
    va_q  <= mag(step_v_x_i);
    vb_q  <= mag(step_v_y_i);
    c1_q  <= cell_size_i;
    nx1_q <= cells_x_i;
    ny1_q <= cells_y_i;
    nxc_q <= ProdW'(cells_x_i) * ProdW'(cell_size_i);
    nyc_q <= ProdW'(cells_y_i) * ProdW'(cell_size_i);
  end

  // second stage: squares, margin test, divider operands
  always_comb begin
    low_x  = $signed({px_q[CoordW-1], px_q}) + $signed({2'b00, c1_q});
    low_y  = $signed({py_q[CoordW-1], py_q}) + $signed({2'b00, c1_q});
    out_x  = (low_x <= 0) || (!px_q[CoordW-1] && (ProdW'(px_q) >= nxc_q));
    out_y  = (low_y <= 0) || (!py_q[CoordW-1] && (ProdW'(py_q) >= nyc_q));
    side_d = '{outside: out_x || out_y, cells_x: nx1_q, cells_y: ny1_q};
  end

  always_ff @(posedge clk_i) begin
    uaa_q   <= SqW'(ua_q) * SqW'(ua_q);
    ubb_q   <= SqW'(ub_q) * SqW'(ub_q);
    vaa_q   <= SqW'(va_q) * SqW'(va_q);
    vbb_q   <= SqW'(vb_q) * SqW'(vb_q);
    posx_q  <= px_q[CoordW-1] ? '0 : px_q[CellW-1:0];
    posy_q  <= py_q[CoordW-1] ? '0 : py_q[CellW-1:0];
    negx_q  <= px_q[CoordW-1];
    negy_q  <= py_q[CoordW-1];
    negmx_q <= CellW'(CoordW'(c1_q) + CoordW'(px_q));
    negmy_q <= CellW'(CoordW'(c1_q) + CoordW'(py_q));
    c2_q    <= c1_q;
    side_q[0] <= side_d;
    for (int k = 1; k <= LocLat; k++) side_q[k] <= side_q[k-1];
    su_q    <= uaa_q + ubb_q;
    sv_q    <= vaa_q + vbb_q;
  end

  acs_locate u_loc_x (
    .clk_i,
    .pos_i   (posx_q),
    .size_i  (c2_q),
    .neg_m_i (negmx_q),
    .neg_i   (negx_q),
    .idx_o   (idx_x),
    .dist_o  (dist_x)
  );

  acs_locate u_loc_y (
    .clk_i,
    .pos_i   (posy_q),
    .size_i  (c2_q),
    .neg_m_i (negmy_q),
    .neg_i   (negy_q),
    .idx_o   (idx_y),
    .dist_o  (dist_y)
  );

  acs_isqrt u_sqrt_u (
    .clk_i,
    .sq_i   (su_q),
    .root_o (root_u)
  );

  acs_isqrt u_sqrt_v (
    .clk_i,
    .sq_i   (sv_q),
    .root_o (root_v)
  );

  // cell parity and border ring
  always_comb begin
    light  = (idx_x[0] == idx_y[0]);
    border = (idx_x == '0) || (idx_y == '0) ||
             (idx_x == side_q[LocLat].cells_x) || (idx_y == side_q[LocLat].cells_y);
    cls_d.gap = (dist_x < dist_y) ? dist_x : dist_y;
    if (side_q[LocLat].outside || (light && border)) begin
      cls_d.kind = KIND_WHITE;
    end else if (light) begin
      cls_d.kind = KIND_LIGHT;
    end else begin
      cls_d.kind = KIND_DARK;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q[0] <= cls_d;
    for (int k = 1; k <= ClsDly; k++) cls_q[k] <= cls_q[k-1];
    job_q.kind   <= cls_q[ClsDly].kind;
    job_q.gap    <= cls_q[ClsDly].gap;
    job_q.smooth <= (root_u < root_v) ? root_u : root_v;
  end

  assign push_o = vld_q[FrontLat-1];
  assign job_o  = job_q;

endmodule

[hdl/acs_fifo.sv]
// short queue of shading jobs between front and back
// depends on acs_pkg
module acs_fifo import acs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t job_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? PtrW'((int'(wr_q) + 1) % QueueDepth) : wr_q;
    rd_d  = do_pop ? PtrW'((int'(rd_q) + 1) % QueueDepth) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

[hdl/acs_back.sv]
// back part: shading ratio by bit per stage division, clip to gray level
// depends on acs_pkg
module acs_back import acs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  job_t              job_i,
  output logic              valid_o,
  output logic [LevelW-1:0] gray_o
);

  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [QuotW-1:0] quo;
    logic [RootW-1:0] smooth;
    kind_e            kind;
    logic             sat;
  } div_stage_t;

  logic             vld_q [QuotW+1];
  logic [NumW-1:0]  num_q;
  logic [RootW-1:0] s_q;
  kind_e            kind_q;
  div_stage_t       stg_in [QuotW];
  div_stage_t       stg_nx [QuotW];
  div_stage_t       stg_q  [QuotW];
  logic [DivW-1:0]  trial  [QuotW];
  div_stage_t       last;
  logic [QuotW:0]   q_ceil;
  logic [LevelW-1:0] gray_d, gray_q;
  logic             out_vld_q;

  always_ff @(posedge clk_i) begin
    num_q  <= NumW'(job_i.gap) * NumW'(MidLevel);
    s_q    <= job_i.smooth;
    kind_q <= job_i.kind;
  end

  always_comb begin
    stg_in[0] = '{rem: num_q, quo: '0, smooth: s_q, kind: kind_q,
                  sat: (DivW'(num_q) >= {s_q, {QuotW{1'b0}}})};
    for (int k = 1; k < QuotW; k++) begin
      stg_in[k] = stg_q[k-1];
    end
    for (int k = 0; k < QuotW; k++) begin
      trial[k]  = DivW'(stg_in[k].smooth) << (QuotW - 1 - k);
      stg_nx[k] = stg_in[k];
      if (DivW'(stg_in[k].rem) >= trial[k]) begin
        stg_nx[k].rem = NumW'(DivW'(stg_in[k].rem) - trial[k]);
        stg_nx[k].quo[QuotW-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QuotW; k++) begin
      stg_q[k] <= stg_nx[k];
    end
  end

  always_comb begin
    last   = stg_q[QuotW-1];
    q_ceil = {1'b0, last.quo} + (QuotW+1)'(last.rem != '0);
    case (last.kind)
      KIND_LIGHT: begin
        gray_d = (last.sat || last.quo >= LightSpan) ? MaxLevel : MidLevel + last.quo;
      end
      KIND_DARK: begin
        gray_d = (last.sat || q_ceil >= (QuotW+1)'(MidLevel)) ? '0 :
                 LevelW'((QuotW+1)'(MidLevel) - q_ceil);
      end
      default: begin
        gray_d = MaxLevel;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    gray_q <= gray_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QuotW; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= QuotW; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[QuotW];
    end
  end

  assign valid_o = out_vld_q;
  assign gray_o  = gray_q;

endmodule

[hdl/antialiased_checkerboard_shade.sv]
// checkerboard shade top: one word per cycle, with a result strobe for each accepted word
// front pipeline is 36 stages, set by the 32 stage square root of the footprint
// one queue stage, then the back adds 10 stages for the division; one word per clock
// reset clears valid bits, the queue and the registers to 8, 6 and 65536
// results cannot be held off, so the queue never fills and busy stays low
// depends on acs_pkg, acs_front, acs_fifo, acs_back
module antialiased_checkerboard_shade import acs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] step_u_x_i,
  input  logic signed [CoordW-1:0] step_u_y_i,
  input  logic signed [CoordW-1:0] step_v_x_i,
  input  logic signed [CoordW-1:0] step_v_y_i,
  output logic                     result_valid_o,
  output logic [LevelW-1:0]        gray_level_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CellW-1:0]         cfg_data_i
);

  logic [CountW-1:0] cells_x_q, cells_y_q;
  logic [CellW-1:0]  cell_size_q;
  logic              accept;
  logic              front_push;
  job_t              front_job;
  logic              queue_valid, queue_full;
  job_t              queue_job;

  assign cfg_ready_o = 1'b1;
  assign busy        = queue_full;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q   <= CellsXReset;
      cells_y_q   <= CellsYReset;
      cell_size_q <= CellSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CELLS_X:   cells_x_q   <= cfg_data_i[CountW-1:0];
        CFG_CELLS_Y:   cells_y_q   <= cfg_data_i[CountW-1:0];
        CFG_CELL_SIZE: cell_size_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  acs_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .point_x_i,
    .point_y_i,
    .step_u_x_i,
    .step_u_y_i,
    .step_v_x_i,
    .step_v_y_i,
    .cells_x_i   (cells_x_q),
    .cells_y_i   (cells_y_q),
    .cell_size_i (cell_size_q),
    .push_o      (front_push),
    .job_o       (front_job)
  );

  acs_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (front_push),
    .job_i   (front_job),
    .pop_i   (1'b1),
    .valid_o (queue_valid),
    .full_o  (queue_full),
    .job_o   (queue_job)
  );

  acs_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (queue_valid),
    .job_i   (queue_job),
    .valid_o (result_valid_o),
    .gray_o  (gray_level_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !queue_full)
    else $error("queue overflow");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("queue filled up");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_valid |=> !queue_valid || $past(front_push))
    else $error("queue word not taken by back part");
`endif

endmodule
